// ===== rtl/lob_pkg.sv =====
// ----------------------------------------------------------------------------
// lob_pkg
// Shared constants, codes and types for the limit order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lob_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int PRICE_BITS  = 16;
  localparam int QTY_BITS    = 24;
  localparam int ID_BITS     = 32;
  localparam int MAX_TRADES  = 32;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int TRD_W       = $clog2(MAX_TRADES);
  localparam int CNT_W       = $clog2(MAX_TRADES + 1);

  // operation codes
  localparam logic [1:0] OP_NEW     = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  // outcome codes
  localparam logic [2:0] OUTC_RESTED    = 3'd0;
  localparam logic [2:0] OUTC_FILLED    = 3'd1;
  localparam logic [2:0] OUTC_MKT_DROP  = 3'd2;
  localparam logic [2:0] OUTC_FULL      = 3'd3;
  localparam logic [2:0] OUTC_RESTORED  = 3'd4;
  localparam logic [2:0] OUTC_CANCELLED = 3'd5;
  localparam logic [2:0] OUTC_NOT_FOUND = 3'd6;
  localparam logic [2:0] OUTC_TRADE     = 3'd0;

  typedef struct packed {
    logic [1:0]            operation;
    logic [ID_BITS-1:0]    order_id;
    logic                  is_sell;
    logic                  is_market;
    logic [PRICE_BITS-1:0] limit_price;
    logic [QTY_BITS-1:0]   order_qty;
  } in_t;

  typedef struct packed {
    logic                  is_final;
    logic [ID_BITS-1:0]    buy_id;
    logic [ID_BITS-1:0]    sell_id;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_qty;
    logic [QTY_BITS-1:0]   buy_left;
    logic [QTY_BITS-1:0]   sell_left;
    logic [2:0]            outcome;
    logic [PRICE_BITS-1:0] best_bid;
    logic [PRICE_BITS-1:0] best_ask;
  } out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]    buy_id;
    logic [ID_BITS-1:0]    sell_id;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic [QTY_BITS-1:0]   buy_left;
    logic [QTY_BITS-1:0]   sell_left;
  } trade_t;

  typedef struct packed {
    logic latch;
    logic scan_clr;
    logic scan_step;
    logic act;
    logic rd_clr;
    logic emit_trade;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic can_fill;
    logic has_trades;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/lob_ctrl.sv =====
// ----------------------------------------------------------------------------
// lob_ctrl
// Sequencer: scan passes over the slot table, fills, resolve, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module lob_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lob_pkg::sts_t sts_i,
  output lob_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       final_q, final_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          final_d        = 1'b0;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          if (!final_q) begin
            state_d = S_ACT;
          end else if (sts_i.has_trades) begin
            cmd_o.rd_clr = 1'b1;
            state_d      = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_ACT: begin
        // a fill needs a fresh search; anything else goes to the closing pass
        cmd_o.act      = 1'b1;
        cmd_o.scan_clr = 1'b1;
        final_d        = !sts_i.can_fill;
        state_d        = S_SCAN;
      end
      S_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_trade = 1'b1;
          state_d          = sts_i.rd_last ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lob_dp.sv =====
// ----------------------------------------------------------------------------
// lob_dp
// Slot table, scan trackers, fill and resolve logic, trade buffer, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module lob_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lob_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lob_pkg::out_t      out_data_o,
  input  wire lob_pkg::cmd_t cmd_i,
  output lob_pkg::sts_t      sts_o
);

  localparam int SW = lob_pkg::SLOT_W;
  localparam int PW = lob_pkg::PRICE_BITS;
  localparam int QW = lob_pkg::QTY_BITS;
  localparam int IW = lob_pkg::ID_BITS;
  localparam int NS = lob_pkg::ORDER_SLOTS;

  // slot table
  logic          vld_q  [NS];
  logic          side_q [NS];
  logic [PW-1:0] price_q[NS];
  logic [IW-1:0] id_q   [NS];
  logic [QW-1:0] sqty_q [NS];

  lob_pkg::in_t           item_q;
  logic [QW-1:0]          qty_q;
  logic [lob_pkg::CNT_W-1:0] n_q, rd_idx_q;
  logic [2:0]             outcome_q;
  logic [QW-1:0]          fqty_q;

  // scan trackers
  logic [SW-1:0] sc_q;
  logic          bs_f_q, bb_f_q, fr_f_q, mt_f_q;
  logic [SW-1:0] bs_idx_q, bb_idx_q, fr_idx_q, mt_idx_q;
  logic [PW-1:0] bs_p_q, bb_p_q;
  logic [IW-1:0] bs_id_q, bb_id_q;
  logic [QW-1:0] bs_qty_q, bb_qty_q, mt_qty_q;

  lob_pkg::trade_t trd_mem[lob_pkg::MAX_TRADES];
  lob_pkg::trade_t rd_q;
  lob_pkg::trade_t trd_w;

  lob_pkg::out_t out_q;
  logic          out_vld_q;

  logic          cur_v, cur_s;
  logic [PW-1:0] cur_p;
  logic [IW-1:0] cur_id;
  logic [QW-1:0] cur_qty;
  logic          sell_hit, buy_hit, free_hit, match_hit;

  logic          opp_f;
  logic [SW-1:0] opp_idx;
  logic [PW-1:0] opp_p;
  logic [IW-1:0] opp_id;
  logic [QW-1:0] opp_qty;
  logic          crosses, can_fill;
  logic [QW-1:0] fill, left_in, left_rest;

  logic          rest_en, cancel_en;
  logic [2:0]    res_outc;
  logic [QW-1:0] res_fqty;
  logic [PW-1:0] bid, ask;
  logic          out_free;

  assign cur_v   = vld_q[sc_q];
  assign cur_s   = side_q[sc_q];
  assign cur_p   = price_q[sc_q];
  assign cur_id  = id_q[sc_q];
  assign cur_qty = sqty_q[sc_q];

  // strict compares keep the lower order id on equal prices, the lowest slot on full ties
  assign sell_hit  = cur_v && cur_s && (!bs_f_q || (cur_p < bs_p_q) ||
                     ((cur_p == bs_p_q) && (cur_id < bs_id_q)));
  assign buy_hit   = cur_v && !cur_s && (!bb_f_q || (cur_p > bb_p_q) ||
                     ((cur_p == bb_p_q) && (cur_id < bb_id_q)));
  assign free_hit  = !cur_v && !fr_f_q;
  assign match_hit = cur_v && (cur_id == item_q.order_id) && !mt_f_q;

  assign opp_f   = item_q.is_sell ? bb_f_q   : bs_f_q;
  assign opp_idx = item_q.is_sell ? bb_idx_q : bs_idx_q;
  assign opp_p   = item_q.is_sell ? bb_p_q   : bs_p_q;
  assign opp_id  = item_q.is_sell ? bb_id_q  : bs_id_q;
  assign opp_qty = item_q.is_sell ? bb_qty_q : bs_qty_q;

  assign crosses  = item_q.is_market ||
                    (item_q.is_sell ? !(item_q.limit_price > opp_p)
                                    : !(item_q.limit_price < opp_p));
  assign can_fill = (item_q.operation == lob_pkg::OP_NEW) && (qty_q != '0) &&
                    (n_q < lob_pkg::CNT_W'(lob_pkg::MAX_TRADES)) && opp_f && crosses;

  assign fill      = (qty_q < opp_qty) ? qty_q : opp_qty;
  assign left_in   = qty_q - fill;
  assign left_rest = opp_qty - fill;

  always_comb begin
    trd_w.price = opp_p;
    trd_w.qty   = fill;
    if (item_q.is_sell) begin
      trd_w.buy_id    = opp_id;
      trd_w.sell_id   = item_q.order_id;
      trd_w.buy_left  = left_rest;
      trd_w.sell_left = left_in;
    end else begin
      trd_w.buy_id    = item_q.order_id;
      trd_w.sell_id   = opp_id;
      trd_w.buy_left  = left_in;
      trd_w.sell_left = left_rest;
    end
  end

  always_comb begin
    rest_en   = 1'b0;
    cancel_en = 1'b0;
    res_outc  = lob_pkg::OUTC_NOT_FOUND;
    res_fqty  = '0;
    unique case (item_q.operation)
      lob_pkg::OP_NEW: begin
        res_fqty = qty_q;
        if (qty_q == '0) begin
          res_outc = lob_pkg::OUTC_FILLED;
        end else if (item_q.is_market) begin
          res_outc = lob_pkg::OUTC_MKT_DROP;
        end else if (fr_f_q) begin
          res_outc = lob_pkg::OUTC_RESTED;
          rest_en  = 1'b1;
        end else begin
          res_outc = lob_pkg::OUTC_FULL;
        end
      end
      lob_pkg::OP_RESTORE: begin
        res_fqty = qty_q;
        res_outc = lob_pkg::OUTC_RESTORED;
        if (qty_q != '0) begin
          if (fr_f_q) rest_en = 1'b1;
          else        res_outc = lob_pkg::OUTC_FULL;
        end
      end
      lob_pkg::OP_CANCEL: begin
        if (mt_f_q) begin
          cancel_en = 1'b1;
          res_outc  = lob_pkg::OUTC_CANCELLED;
          res_fqty  = mt_qty_q;
        end
      end
      default: begin
        res_outc = lob_pkg::OUTC_NOT_FOUND;
      end
    endcase
  end

  // valid bits: cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) vld_q[i] <= 1'b0;
    end else if (cmd_i.act) begin
      if (can_fill) begin
        if (left_rest == '0) vld_q[opp_idx] <= 1'b0;
      end else if (rest_en) begin
        vld_q[fr_idx_q] <= 1'b1;
      end else if (cancel_en) begin
        vld_q[mt_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act) begin
      if (can_fill) begin
        sqty_q[opp_idx] <= left_rest;
      end else if (rest_en) begin
        side_q[fr_idx_q]  <= item_q.is_sell;
        price_q[fr_idx_q] <= item_q.limit_price;
        id_q[fr_idx_q]    <= item_q.order_id;
        sqty_q[fr_idx_q]  <= qty_q;
      end
    end
  end

  // item, scan trackers and fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      sc_q     <= '0;
      bs_f_q   <= 1'b0;
      bb_f_q   <= 1'b0;
      fr_f_q   <= 1'b0;
      mt_f_q   <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.latch) n_q <= '0;
      else if (cmd_i.act && can_fill) n_q <= n_q + 1'b1;
      if (cmd_i.scan_clr) begin
        sc_q   <= '0;
        bs_f_q <= 1'b0;
        bb_f_q <= 1'b0;
        fr_f_q <= 1'b0;
        mt_f_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        sc_q <= sc_q + 1'b1;
        if (sell_hit)  bs_f_q <= 1'b1;
        if (buy_hit)   bb_f_q <= 1'b1;
        if (free_hit)  fr_f_q <= 1'b1;
        if (match_hit) mt_f_q <= 1'b1;
      end
      if (cmd_i.rd_clr) rd_idx_q <= '0;
      else if (cmd_i.emit_trade) rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
      qty_q  <= in_data_i.order_qty;
    end else if (cmd_i.act) begin
      if (can_fill) begin
        qty_q <= left_in;
      end else begin
        outcome_q <= res_outc;
        fqty_q    <= res_fqty;
      end
    end
    if (cmd_i.scan_step) begin
      if (sell_hit) begin
        bs_idx_q <= sc_q;  bs_p_q <= cur_p;  bs_id_q <= cur_id;  bs_qty_q <= cur_qty;
      end
      if (buy_hit) begin
        bb_idx_q <= sc_q;  bb_p_q <= cur_p;  bb_id_q <= cur_id;  bb_qty_q <= cur_qty;
      end
      if (free_hit) fr_idx_q <= sc_q;
      if (match_hit) begin
        mt_idx_q <= sc_q;  mt_qty_q <= cur_qty;
      end
    end
  end

  // trade buffer: trades wait here until the closing best prices are known
  always_ff @(posedge clk_i) begin
    if (cmd_i.act && can_fill) trd_mem[n_q[lob_pkg::TRD_W-1:0]] <= trd_w;
    rd_q <= trd_mem[rd_idx_q[lob_pkg::TRD_W-1:0]];
  end

  assign bid      = bb_f_q ? bb_p_q : '0;
  assign ask      = bs_f_q ? bs_p_q : '0;
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_trade || cmd_i.emit_final) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_trade) begin
      out_q.is_final    <= 1'b0;
      out_q.buy_id      <= rd_q.buy_id;
      out_q.sell_id     <= rd_q.sell_id;
      out_q.trade_price <= rd_q.price;
      out_q.trade_qty   <= rd_q.qty;
      out_q.buy_left    <= rd_q.buy_left;
      out_q.sell_left   <= rd_q.sell_left;
      out_q.outcome     <= lob_pkg::OUTC_TRADE;
      out_q.best_bid    <= bid;
      out_q.best_ask    <= ask;
    end else if (cmd_i.emit_final) begin
      out_q.is_final    <= 1'b1;
      out_q.buy_id      <= item_q.order_id;
      out_q.sell_id     <= '0;
      out_q.trade_price <= '0;
      out_q.trade_qty   <= fqty_q;
      out_q.buy_left    <= '0;
      out_q.sell_left   <= '0;
      out_q.outcome     <= outcome_q;
      out_q.best_bid    <= bid;
      out_q.best_ask    <= ask;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign sts_o.scan_last  = (sc_q == SW'(NS - 1));
  assign sts_o.can_fill   = can_fill;
  assign sts_o.has_trades = (n_q != '0);
  assign sts_o.rd_last    = ((rd_idx_q + 1'b1) == n_q);
  assign sts_o.out_free   = out_free;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= lob_pkg::CNT_W'(lob_pkg::MAX_TRADES))
    else $error("trade count past limit");

  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act && can_fill) |-> vld_q[opp_idx])
    else $error("fill against an empty slot");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_trade || cmd_i.emit_final) |-> out_free)
    else $error("output word overwritten");

endmodule

`default_nettype wire

// ===== rtl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book over a slot table, one order at a time.
//
//   channel | dir | handshake              | word
//   in      | in  | in_valid_i/in_stall_o  | lob_pkg::in_t
//   out     | out | out_valid_o/out_stall_i| lob_pkg::out_t
//
// Each search over the slot table visits one slot a cycle. An item runs a
// search pass and an act step per fill, one more pass and act step that
// resolve it, and a closing pass; then each buffered trade is read and
// emitted, and the closing word follows.
// Reset empties the book at once. The input stalls while an item is in work;
// a stalled output holds its word and pauses the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire lob_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output lob_pkg::out_t     out_data_o
);

  lob_pkg::cmd_t cmd;
  lob_pkg::sts_t sts;

  lob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lob_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
